// File: hdl/klvhp_pkg.sv
// Package for the KLV header parser: phase codes, status codes and result type.
package klvhp_pkg;

  // Key byte counter, key register and result field sizes
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned KEY_W   = 128;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned NBYTE_W = 7;

  // BER length octet fields
  localparam logic [7:0] BER_LONG_BIT   = 8'h80;
  localparam logic [6:0] BER_COUNT_MASK = 7'h7f;

  typedef enum logic [1:0] {
    PH_KEY   = 2'd0,
    PH_OCTET = 2'd1,
    PH_LEN   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_OVER  = 2'd1,
    ST_TRUNC = 2'd2
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [HALF_W-1:0]    key_upper;
    logic [HALF_W-1:0]    key_lower;
    logic [HALF_W-1:0]    value_length;
    logic [NBYTE_W-1:0]   length_bytes;
  } result_t;

endpackage

// File: hdl/klvhp_byte_if.sv
// Valid/ready channel carrying one stream byte and the end-of-stream mark.
interface klvhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

// File: hdl/klvhp_hdr_if.sv
// Valid/ready channel carrying one parsed KLV header result.
interface klvhp_hdr_if;
  logic                   valid;
  logic                   ready;
  klvhp_pkg::status_t     status;
  logic [63:0]            key_upper;
  logic [63:0]            key_lower;
  logic [63:0]            value_length;
  logic [6:0]             length_bytes;

  modport source (output valid, output status, output key_upper, output key_lower,
                  output value_length, output length_bytes, input ready);
  modport sink   (input valid, input status, input key_upper, input key_lower,
                  input value_length, input length_bytes, output ready);
endinterface

// File: hdl/klv_header_parser_unit.sv
// KLV header parser: key collection, BER length decoding, two-entry result queue.
//
// Usage: feed the byte stream on "bytes", one transaction per byte. Set stream_end
// on a transaction to mark the end of the stream (data_byte is then ignored).
// Each header gives one transaction on "headers": the 128-bit key split in two
// halves, the decoded length, the long-form length byte count and a status
// (done, length count above MAX_LENGTH_BYTES, or truncated by stream end).
// Throughput: one byte per cycle while bytes.ready is high; the parser state and the
// result are produced by one short combinational step from the accepted byte.
// Output: the result of the byte (or stream end) that completes a header is registered
// in the result register, or in the skid register while the result register is full.
// Stalls: results go through a two-entry output queue (result register plus
// skid register). bytes.ready drops only while both entries are full, so bytes
// keep flowing while one result waits at the output.
// Reset (rst, synchronous): parser returns to key collection with cleared key
// and length, and the result queue is emptied.
module klv_header_parser_unit #(
  parameter int unsigned KEY_BYTES        = 16,
  parameter int unsigned MAX_LENGTH_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst,
  klvhp_byte_if.sink          bytes,
  klvhp_hdr_if.source         headers
);

  localparam logic [klvhp_pkg::CNT_W-1:0] KEY_LAST = klvhp_pkg::CNT_W'(KEY_BYTES);
  localparam logic [6:0]                   MAX_CNT  = 7'(MAX_LENGTH_BYTES);

  // Parser state
  klvhp_pkg::phase_t               phase, phase_next;
  logic [klvhp_pkg::CNT_W-1:0]     byte_counter, byte_counter_next;
  logic [klvhp_pkg::KEY_W-1:0]     key_store, key_store_next;
  logic [63:0]                     length_accumulator, length_accumulator_next;
  logic [3:0]                      pending_length_bytes, pending_length_bytes_next;

  // Result of the current byte
  logic                            res_valid;
  klvhp_pkg::result_t              res;

  // Output queue
  logic                            out_valid, skid_valid;
  klvhp_pkg::result_t              out_data, skid_data;

  logic                            accept;
  logic                            pop;
  logic [klvhp_pkg::CNT_W-1:0]     key_count_inc;
  logic [3:0]                      len_count_inc;
  logic [3:0]                      pending_dec;
  logic [6:0]                      octet_count;
  logic [klvhp_pkg::KEY_W-1:0]     key_shifted;
  logic [63:0]                     acc_shifted;

  assign bytes.ready = !skid_valid;
  assign accept      = bytes.valid && bytes.ready;
  assign pop         = out_valid && headers.ready;

  assign key_count_inc = byte_counter + klvhp_pkg::CNT_W'(1);
  assign len_count_inc = byte_counter[3:0] + 4'd1;
  assign pending_dec   = pending_length_bytes - 4'd1;
  assign octet_count   = bytes.data_byte[6:0] & klvhp_pkg::BER_COUNT_MASK;
  assign key_shifted   = {key_store[klvhp_pkg::KEY_W-9:0], bytes.data_byte};
  assign acc_shifted   = {length_accumulator[55:0], bytes.data_byte};

  // Result for the incoming byte
  always_comb begin
    res_valid        = 1'b0;
    res.status       = klvhp_pkg::ST_DONE;
    res.key_upper    = key_store[127:64];
    res.key_lower    = key_store[63:0];
    res.value_length = '0;
    res.length_bytes = '0;

    if (bytes.stream_end) begin
      // End inside a header reports truncation; between headers nothing happens
      if (!(phase == klvhp_pkg::PH_KEY && byte_counter == '0)) begin
        res_valid  = 1'b1;
        res.status = klvhp_pkg::ST_TRUNC;
      end
    end else begin
      case (phase)
        klvhp_pkg::PH_OCTET: begin
          if ((bytes.data_byte & klvhp_pkg::BER_LONG_BIT) == 8'h00) begin
            res_valid        = 1'b1;
            res.value_length = {56'd0, bytes.data_byte};
          end else if (octet_count > MAX_CNT) begin
            res_valid        = 1'b1;
            res.status       = klvhp_pkg::ST_OVER;
            res.length_bytes = octet_count;
          end else if (octet_count == 7'd0) begin
            res_valid = 1'b1;
          end
        end
        klvhp_pkg::PH_LEN: begin
          if (pending_dec == 4'd0) begin
            res_valid        = 1'b1;
            res.value_length = acc_shifted;
            res.length_bytes = {3'd0, len_count_inc};
          end
        end
        default: begin
          // Key bytes never complete a header
        end
      endcase
    end
  end

  // Next parser state for the incoming byte
  always_comb begin
    phase_next                = phase;
    byte_counter_next         = byte_counter;
    key_store_next            = key_store;
    length_accumulator_next   = length_accumulator;
    pending_length_bytes_next = pending_length_bytes;

    if (!bytes.stream_end) begin
      case (phase)
        klvhp_pkg::PH_OCTET: begin
          // Long-form entry; octets that complete the header are cleared below
          pending_length_bytes_next = octet_count[3:0];
          byte_counter_next         = '0;
          length_accumulator_next   = '0;
          phase_next                = klvhp_pkg::PH_LEN;
        end
        klvhp_pkg::PH_LEN: begin
          length_accumulator_next   = acc_shifted;
          byte_counter_next         = {1'b0, len_count_inc};
          pending_length_bytes_next = pending_dec;
        end
        default: begin
          // Key collection; the unused phase code lands here too
          key_store_next = key_shifted;
          if (key_count_inc >= KEY_LAST) begin
            byte_counter_next = '0;
            phase_next        = klvhp_pkg::PH_OCTET;
          end else begin
            byte_counter_next = key_count_inc;
            phase_next        = klvhp_pkg::PH_KEY;
          end
        end
      endcase
    end

    // Every result ends the header
    if (res_valid) begin
      phase_next                = klvhp_pkg::PH_KEY;
      byte_counter_next         = '0;
      key_store_next            = '0;
      length_accumulator_next   = '0;
      pending_length_bytes_next = '0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= klvhp_pkg::PH_KEY;
      byte_counter         <= '0;
      key_store            <= '0;
      length_accumulator   <= '0;
      pending_length_bytes <= '0;
    end else if (accept) begin
      phase                <= phase_next;
      byte_counter         <= byte_counter_next;
      key_store            <= key_store_next;
      length_accumulator   <= length_accumulator_next;
      pending_length_bytes <= pending_length_bytes_next;
    end
  end

  // Output queue control: result register in front, skid register behind
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          skid_valid <= accept && res_valid;
        end else begin
          out_valid <= accept && res_valid;
        end
      end else if (accept && res_valid) begin
        if (out_valid) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  // Output queue payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (accept && res_valid) begin
          skid_data <= res;
        end
      end else if (accept && res_valid) begin
        out_data <= res;
      end
    end else if (accept && res_valid) begin
      if (out_valid) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end
  end

  assign headers.valid        = out_valid;
  assign headers.status       = out_data.status;
  assign headers.key_upper    = out_data.key_upper;
  assign headers.key_lower    = out_data.key_lower;
  assign headers.value_length = out_data.value_length;
  assign headers.length_bytes = out_data.length_bytes;

`ifndef SYNTHESIS
  // Skid entry never holds a result without the front entry
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty result register");

  // Length phase always has bytes outstanding
  a_pending: assert property (@(posedge clk) disable iff (rst)
    phase == klvhp_pkg::PH_LEN |-> pending_length_bytes != 4'd0)
    else $error("length phase with no pending bytes");

  // Key counter stays below the key size
  a_key_count: assert property (@(posedge clk) disable iff (rst)
    phase == klvhp_pkg::PH_KEY |-> byte_counter < KEY_LAST)
    else $error("key byte counter out of range");

  // A short-form octet completes the header and clears the key
  a_short_form: assert property (@(posedge clk) disable iff (rst)
    accept && !bytes.stream_end && phase == klvhp_pkg::PH_OCTET &&
    !bytes.data_byte[7] |=> phase == klvhp_pkg::PH_KEY && key_store == '0 && out_valid)
    else $error("short-form octet did not complete the header");
`endif

endmodule

// File: tb/tb_klv_header_parser_unit.sv
// Self-checking testbench for the KLV header parser: directed table, then random header streams.
module tb_klv_header_parser_unit;

  localparam int unsigned KEY_LEN       = 16;
  localparam int unsigned MAX_LEN_BYTES = 8;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // One row of the directed table; want is used only when typed is set
  typedef struct {
    logic [7:0]         data;
    logic               stream_end;
    bit                 typed;
    klvhp_pkg::result_t want;
  } stim_row_t;

  localparam klvhp_pkg::result_t NO_HDR = '0;

  logic clk;
  logic rst = 1'b1;

  klvhp_byte_if bytes_if ();
  klvhp_hdr_if  hdr_if ();

  klv_header_parser_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_if),
    .headers (hdr_if)
  );

  // Parser state mirrored by the predictor
  klvhp_pkg::phase_t parse_phase;
  logic [4:0]        taken;
  logic [127:0]      key_shift;
  logic [63:0]       len_acc;
  logic [6:0]        pend;

  klvhp_pkg::result_t hdr_expect[$];
  int unsigned  errors = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  cycles = 0;
  int unsigned  src_idle = 0;
  int unsigned  sink_idle = 0;
  int unsigned  hold_asks = 0;
  int unsigned  holds_taken = 0;
  int unsigned  n_status[3] = '{0, 0, 0};

  // Directed stimulus: idle end, truncation, all-ones key with oversize count
  stim_row_t dir_table [24] = '{
    '{8'h00, 1'b1, 1'b0, NO_HDR},  // stream end with nothing collected
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'h00, 1'b0, 1'b0, NO_HDR},
    '{8'ha5, 1'b1, 1'b1, '{klvhp_pkg::ST_TRUNC, 64'h0, 64'hff00, 64'h0, 7'h0}},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b0, NO_HDR},
    '{8'hff, 1'b0, 1'b1,
      '{klvhp_pkg::ST_OVER, {64{1'b1}}, {64{1'b1}}, 64'h0, 7'h7f}},
    '{8'h5a, 1'b0, 1'b0, NO_HDR},
    '{8'h00, 1'b1, 1'b1, '{klvhp_pkg::ST_TRUNC, 64'h0, 64'h5a, 64'h0, 7'h0}},
    '{8'hff, 1'b1, 1'b0, NO_HDR}   // end between headers again
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d headers outstanding", cycles, hdr_expect.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic clear_parser();
    parse_phase = klvhp_pkg::PH_KEY;
    taken       = '0;
    key_shift   = '0;
    len_acc     = '0;
    pend        = '0;
  endtask

  // Advance the mirrored parser by one byte transaction; got flags a header result
  task automatic parse_byte(input logic [7:0] d, input logic fin,
                            output bit got, output klvhp_pkg::result_t r);
    logic [6:0] count;
    got   = 1'b0;
    r     = '0;
    count = d[6:0] & klvhp_pkg::BER_COUNT_MASK;
    if (fin) begin
      // truncation only when something of a header was taken
      if (parse_phase != klvhp_pkg::PH_KEY || taken != 0) begin
        got      = 1'b1;
        r.status = klvhp_pkg::ST_TRUNC;
      end
    end else begin
      case (parse_phase)
        klvhp_pkg::PH_OCTET: begin
          got = 1'b1;
          if ((d & klvhp_pkg::BER_LONG_BIT) == 0) begin
            r.status       = klvhp_pkg::ST_DONE;
            r.value_length = {56'h0, d};
          end else if (count > MAX_LEN_BYTES) begin
            r.status       = klvhp_pkg::ST_OVER;
            r.length_bytes = count;
          end else if (count == 0) begin
            r.status = klvhp_pkg::ST_DONE;  // indefinite octet
          end else begin
            got         = 1'b0;
            pend        = count;
            taken       = '0;
            len_acc     = '0;
            parse_phase = klvhp_pkg::PH_LEN;
          end
        end
        klvhp_pkg::PH_LEN: begin
          len_acc = {len_acc[55:0], d};
          taken   = taken + 1'b1;
          if (pend > 0) pend = pend - 1'b1;
          if (pend == 0) begin
            got            = 1'b1;
            r.status       = klvhp_pkg::ST_DONE;
            r.value_length = len_acc;
            r.length_bytes = {2'b00, taken};
          end
        end
        default: begin
          key_shift = {key_shift[119:0], d};
          taken     = taken + 1'b1;
          if (taken >= KEY_LEN) begin
            taken       = '0;
            parse_phase = klvhp_pkg::PH_OCTET;
          end
        end
      endcase
    end
    if (got) begin
      r.key_upper = key_shift[127:64];
      r.key_lower = key_shift[63:0];
      clear_parser();
    end
  endtask

  // Offer one byte transaction, wait for acceptance, record what it should produce
  task automatic send_item(input logic [7:0] d, input logic fin,
                           input bit typed, input klvhp_pkg::result_t want);
    bit                 got;
    klvhp_pkg::result_t r;
    while ($urandom_range(0, 99) < src_idle) begin
      bytes_if.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_if.valid      <= 1'b1;
    bytes_if.data_byte  <= d;
    bytes_if.stream_end <= fin;
    @(posedge clk);
    while (!bytes_if.ready) @(posedge clk);
    bytes_sent++;
    parse_byte(d, fin, got, r);
    if (typed) hdr_expect.push_back(want);
    else if (got) hdr_expect.push_back(r);
  endtask

  function automatic logic [7:0] rand_byte();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  // One well-formed header with random content, sometimes cut short by stream end
  task automatic send_header();
    logic [7:0]  seq[$];
    int unsigned form;
    int unsigned nlen;
    int unsigned cut;
    for (int i = 0; i < KEY_LEN; i++) seq.push_back(rand_byte());
    form = $urandom_range(0, 9);
    nlen = 0;
    case (form)
      0, 1:    seq.push_back(8'($urandom_range(0, 127)));
      2:       seq.push_back(($urandom_range(0, 1) != 0) ? 8'h7f : 8'h00);
      3:       seq.push_back(klvhp_pkg::BER_LONG_BIT);  // indefinite
      4:       seq.push_back(klvhp_pkg::BER_LONG_BIT |
                             8'($urandom_range(MAX_LEN_BYTES + 1, 127)));
      default: begin
        nlen = ($urandom_range(0, 3) == 0) ? MAX_LEN_BYTES : $urandom_range(1, MAX_LEN_BYTES);
        seq.push_back(klvhp_pkg::BER_LONG_BIT | 8'(nlen));
      end
    endcase
    for (int i = 0; i < nlen; i++) seq.push_back(rand_byte());
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(0, seq.size() - 1);
      for (int i = 0; i < cut; i++) send_item(seq[i], 1'b0, 1'b0, NO_HDR);
      send_item(rand_byte(), 1'b1, 1'b0, NO_HDR);
    end else begin
      foreach (seq[i]) send_item(seq[i], 1'b0, 1'b0, NO_HDR);
    end
  endtask

  // Unstructured bytes and stream ends; leaves the parser misaligned
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(5, 30);
    for (int i = 0; i < n; i++)
      send_item(rand_byte(), ($urandom_range(0, 5) == 0), 1'b0, NO_HDR);
  endtask

  // Sender pause until every expected header is back
  task automatic drain();
    bytes_if.valid <= 1'b0;
    @(posedge clk);
    while (hdr_expect.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: header %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result side: check each header transaction, randomize ready, honor hold requests
  initial begin
    int unsigned        hold_left;
    klvhp_pkg::result_t want;
    hold_left = 0;
    hdr_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && hdr_if.valid && hdr_if.ready) begin
        if (hdr_expect.size() == 0) begin
          $display("%0t: unexpected header, expected none, actual status %0d key %h_%h",
                   $time, hdr_if.status, hdr_if.key_upper, hdr_if.key_lower);
          errors++;
        end else begin
          want = hdr_expect.pop_front();
          check_field("status", 64'(want.status), 64'(hdr_if.status));
          check_field("key_upper", want.key_upper, hdr_if.key_upper);
          check_field("key_lower", want.key_lower, hdr_if.key_lower);
          check_field("value_length", want.value_length, hdr_if.value_length);
          check_field("length_bytes", 64'(want.length_bytes), 64'(hdr_if.length_bytes));
          if (hdr_if.status <= klvhp_pkg::ST_TRUNC) n_status[hdr_if.status]++;
        end
      end
      if (hold_asks != holds_taken) begin
        holds_taken = hold_asks;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        hdr_if.ready <= 1'b0;
      end else begin
        hdr_if.ready <= ($urandom_range(0, 99) >= sink_idle);
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned phase_end[3];
    phase_end = '{380, 740, 1100};
    bytes_if.valid      <= 1'b0;
    bytes_if.data_byte  <= 8'h00;
    bytes_if.stream_end <= 1'b0;
    clear_parser();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0:       begin src_idle = 34; sink_idle = 66; end
        1:       begin src_idle = 66; sink_idle = 34; end
        default: begin src_idle = 0;  sink_idle = 0;  end
      endcase
      if (p == 0)
        foreach (dir_table[i])
          send_item(dir_table[i].data, dir_table[i].stream_end,
                    dir_table[i].typed, dir_table[i].want);
      // long receiver stall while bytes keep coming
      hold_asks++;
      while (bytes_sent < phase_end[p]) begin
        if ($urandom_range(0, 99) < 85) send_header();
        else send_noise();
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (hdr_expect.size() != 0) begin
      $display("%0t: %0d expected headers never arrived", $time, hdr_expect.size());
      errors++;
    end
    $display("Sent %0d byte transactions over three idle mixes with %0d long output stalls.",
             bytes_sent, hold_asks);
    $display("Headers checked: %0d complete, %0d oversize count, %0d truncated; %0d errors.",
             n_status[klvhp_pkg::ST_DONE], n_status[klvhp_pkg::ST_OVER],
             n_status[klvhp_pkg::ST_TRUNC], errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/klvhp_pkg.sv
hdl/klvhp_byte_if.sv
hdl/klvhp_hdr_if.sv
hdl/klv_header_parser_unit.sv
tb/tb_klv_header_parser_unit.sv
